>>> sv/pwdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the PCI DMA window translator.
// No dependencies.

package pwdt_pkg;

	localparam int NUM_WINDOWS = 4;
	localparam int WIN_REGS = 4;
	localparam int WIN_USED = (NUM_WINDOWS < WIN_REGS) ? NUM_WINDOWS : WIN_REGS;
	localparam int WIN_IDX_W = $clog2(WIN_REGS);
	localparam int HIT_W = 3;

	localparam logic [HIT_W-1:0] NO_HIT = 3'd4;

	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_XLATE = 2'd2;
	localparam logic [1:0] ACT_REPLY = 2'd3;

	localparam logic [1:0] KIND_REG   = 2'd0;
	localparam logic [1:0] KIND_ADDR  = 2'd1;
	localparam logic [1:0] KIND_FETCH = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_UNIMPL   = 2'd1;
	localparam logic [1:0] ST_UNKNOWN  = 2'd2;
	localparam logic [1:0] ST_NO_FETCH = 2'd3;

	localparam logic [4:0] REG_BASE0     = 5'd0;
	localparam logic [4:0] REG_BASE_LAST = 5'd3;
	localparam logic [4:0] REG_MASK0     = 5'd4;
	localparam logic [4:0] REG_MASK_LAST = 5'd7;
	localparam logic [4:0] REG_TBASE0    = 5'd8;
	localparam logic [4:0] REG_TBASE_LAST = 5'd11;
	localparam logic [4:0] REG_CTL       = 5'd12;
	localparam logic [4:0] REG_PERROR    = 5'd15;
	localparam logic [4:0] REG_PERRMASK  = 5'd16;
	localparam logic [4:0] REG_TLBIA     = 5'd19;
	localparam logic [4:0] REG_LAST_KNOWN = 5'd21;

	localparam logic [63:0] CTL_RESET = 64'h0000_0021_0010_0000;

	typedef struct packed {
		logic [1:0]  action;
		logic [4:0]  reg_index;
		logic [63:0] write_value;
		logic [31:0] bus_address;
		logic [63:0] page_entry;
	} req_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [1:0]       status;
		logic [63:0]      read_value;
		logic [33:0]      dma_address;
		logic [63:0]      fetch_address;
		logic [HIT_W-1:0] window_hit;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} dp_cmd_t;

endpackage

>>> sv/pwdt_ctrl.sv
`timescale 1ns / 1ps
// Controller for the window translator: request/response handshake sequencing.
// Depends on pwdt_pkg.

module pwdt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output pwdt_pkg::dp_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;
	logic   out_free;

	assign req_ready   = (state_q == S_IDLE);
	assign rsp_valid   = rsp_valid_q;
	assign out_free    = !rsp_valid_q || rsp_ready;
	assign cmd.capture = (state_q == S_IDLE) && req_valid;
	assign cmd.execute = (state_q == S_EXEC) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rsp_ready)
						rsp_valid_q <= 1'b0;
					if (req_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					rsp_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

>>> sv/pwdt_datapath.sv
`timescale 1ns / 1ps
// Datapath: window register file, window match, address merge, result register.
// Depends on pwdt_pkg.

module pwdt_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  pwdt_pkg::dp_cmd_t cmd,
	input  pwdt_pkg::req_t    req,
	output pwdt_pkg::rsp_t    rsp
);

	pwdt_pkg::req_t item_q;
	pwdt_pkg::rsp_t rsp_q;
	pwdt_pkg::rsp_t rsp_d;

	logic [63:0] base_q  [pwdt_pkg::WIN_REGS];
	logic [63:0] mask_q  [pwdt_pkg::WIN_REGS];
	logic [63:0] tbase_q [pwdt_pkg::WIN_REGS];
	logic [63:0] ctl_q;
	logic        fetch_pending_q;
	logic [12:0] pend_off_q;
	logic [pwdt_pkg::HIT_W-1:0] pend_win_q;

	logic [pwdt_pkg::WIN_REGS-1:0]  match;
	logic                           hit_found;
	logic [pwdt_pkg::WIN_IDX_W-1:0] hit_idx;
	logic [pwdt_pkg::WIN_IDX_W-1:0] sel;
	logic [63:0] base_sel, mask_sel, tbase_sel;
	logic [63:0] msk, tmask, bmask_sg, bmask_dir, bus64, fa;
	logic [63:0] dma_dir;
	logic [1:0]  reg_status;
	logic [63:0] reg_rdata;

	assign rsp   = rsp_q;
	assign bus64 = {32'd0, item_q.bus_address};

	always_comb begin
		for (int i = 0; i < pwdt_pkg::WIN_REGS; i++) begin
			match[i] = (i < pwdt_pkg::WIN_USED) && base_q[i][0]
				&& (((item_q.bus_address[31:20] ^ base_q[i][31:20])
				& ~mask_q[i][31:20]) == 12'd0);
		end
		hit_found = 1'b0;
		hit_idx   = '0;
		for (int i = pwdt_pkg::WIN_REGS - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_found = 1'b1;
				hit_idx   = pwdt_pkg::WIN_IDX_W'(i);
			end
		end
	end

	// one read port: hit window for translations, register index otherwise
	assign sel = (item_q.action == pwdt_pkg::ACT_XLATE) ? hit_idx
		: item_q.reg_index[pwdt_pkg::WIN_IDX_W-1:0];
	assign base_sel  = base_q[sel];
	assign mask_sel  = mask_q[sel];
	assign tbase_sel = tbase_q[sel];

	assign msk       = {32'd0, mask_sel[31:20], 20'd0};
	assign tmask     = ~((msk >> 10) | 64'h3ff);
	assign bmask_sg  = msk | (64'h7f << 13);
	assign fa        = (tbase_sel & tmask) | ((bus64 & bmask_sg) >> 10);
	assign bmask_dir = msk | 64'hfffff;
	assign dma_dir   = (tbase_sel & ~bmask_dir) | (bus64 & bmask_dir);

	always_comb begin
		reg_rdata = 64'd0;
		case (item_q.reg_index) inside
			[pwdt_pkg::REG_BASE0:pwdt_pkg::REG_BASE_LAST]: begin
				reg_status = pwdt_pkg::ST_OK;
				reg_rdata  = base_sel;
			end
			[pwdt_pkg::REG_MASK0:pwdt_pkg::REG_MASK_LAST]: begin
				reg_status = pwdt_pkg::ST_OK;
				reg_rdata  = mask_sel;
			end
			[pwdt_pkg::REG_TBASE0:pwdt_pkg::REG_TBASE_LAST]: begin
				reg_status = pwdt_pkg::ST_OK;
				reg_rdata  = tbase_sel;
			end
			pwdt_pkg::REG_CTL: begin
				reg_status = pwdt_pkg::ST_OK;
				reg_rdata  = ctl_q;
			end
			pwdt_pkg::REG_PERROR, pwdt_pkg::REG_TLBIA: begin
				reg_status = pwdt_pkg::ST_OK;
			end
			pwdt_pkg::REG_PERRMASK: begin
				reg_status = (item_q.action == pwdt_pkg::ACT_READ)
					? pwdt_pkg::ST_OK : pwdt_pkg::ST_UNIMPL;
			end
			[pwdt_pkg::REG_CTL:pwdt_pkg::REG_LAST_KNOWN]: begin
				reg_status = pwdt_pkg::ST_UNIMPL;
			end
			default: begin
				reg_status = pwdt_pkg::ST_UNKNOWN;
			end
		endcase
	end

	always_comb begin
		rsp_d               = '0;
		rsp_d.window_hit    = pwdt_pkg::NO_HIT;
		case (item_q.action)
			pwdt_pkg::ACT_READ: begin
				rsp_d.kind       = pwdt_pkg::KIND_REG;
				rsp_d.status     = reg_status;
				rsp_d.read_value = reg_rdata;
			end
			pwdt_pkg::ACT_WRITE: begin
				rsp_d.kind   = pwdt_pkg::KIND_REG;
				rsp_d.status = reg_status;
			end
			pwdt_pkg::ACT_XLATE: begin
				rsp_d.status = pwdt_pkg::ST_OK;
				if (!hit_found) begin
					rsp_d.kind        = pwdt_pkg::KIND_ADDR;
					rsp_d.dma_address = {2'd0, item_q.bus_address};
				end else if (base_sel[1]) begin
					rsp_d.kind          = pwdt_pkg::KIND_FETCH;
					rsp_d.fetch_address = fa;
					rsp_d.window_hit    = pwdt_pkg::HIT_W'(hit_idx);
				end else begin
					rsp_d.kind        = pwdt_pkg::KIND_ADDR;
					rsp_d.dma_address = dma_dir[33:0];
					rsp_d.window_hit  = pwdt_pkg::HIT_W'(hit_idx);
				end
			end
			default: begin
				rsp_d.kind = pwdt_pkg::KIND_ADDR;
				if (fetch_pending_q) begin
					rsp_d.status      = pwdt_pkg::ST_OK;
					rsp_d.dma_address = {item_q.page_entry[21:1], pend_off_q};
					rsp_d.window_hit  = pend_win_q;
				end else begin
					rsp_d.status = pwdt_pkg::ST_NO_FETCH;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture)
			item_q <= req;
		if (cmd.execute)
			rsp_q <= rsp_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pwdt_pkg::WIN_REGS; i++) begin
				base_q[i]  <= 64'd0;
				mask_q[i]  <= 64'd0;
				tbase_q[i] <= 64'd0;
			end
			ctl_q           <= pwdt_pkg::CTL_RESET;
			fetch_pending_q <= 1'b0;
			pend_off_q      <= 13'd0;
			pend_win_q      <= pwdt_pkg::NO_HIT;
		end else if (cmd.execute) begin
			case (item_q.action)
				pwdt_pkg::ACT_WRITE: begin
					case (item_q.reg_index) inside
						[pwdt_pkg::REG_BASE0:pwdt_pkg::REG_BASE_LAST]: begin
							base_q[sel] <= item_q.write_value;
						end
						[pwdt_pkg::REG_MASK0:pwdt_pkg::REG_MASK_LAST]: begin
							mask_q[sel] <= item_q.write_value;
						end
						[pwdt_pkg::REG_TBASE0:pwdt_pkg::REG_TBASE_LAST]: begin
							tbase_q[sel] <= item_q.write_value;
						end
						pwdt_pkg::REG_CTL: begin
							ctl_q <= item_q.write_value;
						end
						default: begin
						end
					endcase
				end
				pwdt_pkg::ACT_XLATE: begin
					if (hit_found && base_sel[1]) begin
						fetch_pending_q <= 1'b1;
						pend_off_q      <= item_q.bus_address[12:0];
						pend_win_q      <= pwdt_pkg::HIT_W'(hit_idx);
					end
				end
				pwdt_pkg::ACT_REPLY: begin
					fetch_pending_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

>>> sv/pci_window_dma_translator_core.sv
`timescale 1ns / 1ps
// PCI DMA window translator, top level: controller plus datapath.
// Depends on pwdt_pkg, pwdt_ctrl, pwdt_datapath.
//
// Each request beat yields exactly one response beat. A request is taken in
// the idle state and resolved in the execute state, where the window
// compares, the register file read and the address merge run as one step
// into the response register, a step held off while a finished response is
// still held by rsp_ready; a new request is taken only after it. A new request
// is accepted while the previous response waits. Window registers reset
// to zero, the control register to 0x2100100000; no clearing pass is needed.

module pci_window_dma_translator_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  pwdt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output pwdt_pkg::rsp_t rsp
);

	pwdt_pkg::dp_cmd_t cmd;

	pwdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	pwdt_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

>>> sv/pwdt_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the window translator, bound to the top level.
// Depends on pwdt_pkg and pci_window_dma_translator_core.

module pwdt_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input pwdt_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response beat dropped or changed while stalled");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous beat still in work");

	a_reg_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == pwdt_pkg::KIND_REG |->
		rsp.window_hit == pwdt_pkg::NO_HIT && rsp.dma_address == 34'd0
		&& rsp.fetch_address == 64'd0)
		else $error("register beat carries address fields");

	a_fetch_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == pwdt_pkg::KIND_FETCH |->
		rsp.window_hit != pwdt_pkg::NO_HIT && rsp.status == pwdt_pkg::ST_OK
		&& rsp.dma_address == 34'd0)
		else $error("fetch beat without a window hit");

	a_no_fetch_reply: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == pwdt_pkg::ST_NO_FETCH |->
		rsp.kind == pwdt_pkg::KIND_ADDR && rsp.window_hit == pwdt_pkg::NO_HIT
		&& rsp.dma_address == 34'd0)
		else $error("failed reply beat malformed");

endmodule

bind pci_window_dma_translator_core pwdt_checker u_pwdt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
